// ===== design/fix_tcc_pkg.sv =====
// fix_tcc_pkg: shared types and constants of the trailer checksum checker
// no dependencies; imported by fix_tcc_path and the top level

package fix_tcc_pkg;

  localparam logic [7:0] SOH_BYTE  = 8'h01;
  localparam logic [7:0] PIPE_BYTE = 8'h7C;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_EQ   = 8'h3D;

  localparam int unsigned ValueW   = 9;
  localparam int unsigned ProdW    = 12;
  localparam logic [ValueW-1:0] VALUE_SAT = 9'd256;
  localparam logic [ValueW-1:0] VALUE_MAX = 9'd255;

  typedef enum logic [2:0] {
    ST_SEARCH = 3'd0,
    ST_DELIM  = 3'd1,
    ST_ONE    = 3'd2,
    ST_ZERO   = 3'd3,
    ST_VALUE  = 3'd4,
    ST_ENDED  = 3'd5
  } stage_e;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_NO_TRAILER = 3'd1,
    STAT_MALFORMED  = 3'd2,
    STAT_OVER       = 3'd3,
    STAT_MISMATCH   = 3'd4
  } status_e;

  // per-delimiter search and parse state
  typedef struct packed {
    stage_e              stage;
    logic [7:0]          frozen_sum;
    logic [ValueW-1:0]   value;
    logic                digit_seen;
    logic                bad_digit;
  } path_view_t;

endpackage

// ===== design/fix_tcc_if.sv =====
// fix_tcc_byte_if and fix_tcc_res_if: valid/ready channels of the checker
// depends on nothing but plain logic types

interface fix_tcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fix_tcc_res_if;
  logic       valid;
  logic       ready;
  logic       checksum_ok;
  logic [2:0] status_code;
  logic [7:0] computed_sum;
  logic [7:0] declared_value;
  logic       used_soh;

  modport source (output valid, output checksum_ok, output status_code,
                  output computed_sum, output declared_value, output used_soh,
                  input ready);
  modport sink   (input valid, input checksum_ok, input status_code,
                  input computed_sum, input declared_value, input used_soh,
                  output ready);
endinterface

// ===== design/fix_trailer_checksum_checker.sv =====
// fix_trailer_checksum_checker: top level of the trailer checksum checker
// depends on fix_tcc_pkg, fix_tcc_if.sv and fix_tcc_path
//
//   port    dir   handshake      payload
//   in_i    in    valid/ready    data_byte[7:0], last_byte
//   res_o   out   valid/ready    checksum_ok, status_code[2:0], computed_sum[7:0],
//                                declared_value[7:0], used_soh
//
// one byte per cycle unless the input is stalled: a byte is registered on entry and
// processed from the input register; a result leaves from the result register
// only a last byte meeting a full, stalled result register holds the input
// asynchronous active-low reset clears all message state; state also clears
// after every last byte

module fix_trailer_checksum_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  fix_tcc_byte_if.sink        in_i,
  fix_tcc_res_if.source       res_o
);
  import fix_tcc_pkg::*;

  // input register
  logic       s1_vld_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_go;

  // message state
  logic [7:0] running_sum_q, sum_next;
  logic       soh_seen_q, soh_seen_d;

  path_view_t soh_view, pipe_view, sel_view;

  // result register
  logic       out_vld_q;
  logic       ok_q, ok_d;
  status_e    status_q, status_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] decl_q, decl_d;
  logic       soh_q;

  assign s1_go      = s1_vld_q && (!s1_last_q || !out_vld_q || res_o.ready);
  assign in_i.ready = !s1_vld_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  assign sum_next   = running_sum_q + s1_byte_q;
  assign soh_seen_d = soh_seen_q || (s1_byte_q == SOH_BYTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= '0;
      soh_seen_q    <= 1'b0;
    end else if (s1_go) begin
      if (s1_last_q) begin
        running_sum_q <= '0;
        soh_seen_q    <= 1'b0;
      end else begin
        running_sum_q <= sum_next;
        soh_seen_q    <= soh_seen_d;
      end
    end
  end

  fix_tcc_path u_soh_path (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_go),
    .clear_i    (s1_last_q),
    .delim_i    (SOH_BYTE),
    .byte_i     (s1_byte_q),
    .sum_next_i (sum_next),
    .view_o     (soh_view)
  );

  fix_tcc_path u_pipe_path (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_go),
    .clear_i    (s1_last_q),
    .delim_i    (PIPE_BYTE),
    .byte_i     (s1_byte_q),
    .sum_next_i (sum_next),
    .view_o     (pipe_view)
  );

  // verdict from the path state including the last byte
  always_comb begin
    sel_view = soh_seen_d ? soh_view : pipe_view;
    sum_d    = '0;
    decl_d   = '0;
    if (sel_view.stage != ST_VALUE && sel_view.stage != ST_ENDED) begin
      status_d = STAT_NO_TRAILER;
    end else begin
      sum_d = sel_view.frozen_sum;
      if (!sel_view.digit_seen || sel_view.bad_digit) begin
        status_d = STAT_MALFORMED;
      end else if (sel_view.value > VALUE_MAX) begin
        status_d = STAT_OVER;
      end else begin
        decl_d   = sel_view.value[7:0];
        status_d = (decl_d == sum_d) ? STAT_OK : STAT_MISMATCH;
      end
    end
    ok_d = (status_d == STAT_OK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      ok_q     <= ok_d;
      status_q <= status_d;
      sum_q    <= sum_d;
      decl_q   <= decl_d;
      soh_q    <= soh_seen_d;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.checksum_ok    = ok_q;
  assign res_o.status_code    = status_q;
  assign res_o.computed_sum   = sum_q;
  assign res_o.declared_value = decl_q;
  assign res_o.used_soh       = soh_q;

  // message state starts clean after every last byte
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_last_q |=> running_sum_q == 8'd0 && !soh_seen_q)
    else $error("message state not cleared after last item");

  a_ok_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ok_q == (status_q == STAT_OK))
    else $error("checksum_ok disagrees with status");

  a_no_trailer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && status_q == STAT_NO_TRAILER |-> sum_q == 8'd0 && decl_q == 8'd0)
    else $error("no-trailer result carries nonzero fields");

  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_vld_q && s1_last_q && out_vld_q && !res_o.ready)
    else $error("input stalled without a blocked last item");

endmodule

// ===== design/fix_tcc_path.sv =====
// fix_tcc_path: trailer search and value parse for one delimiter
// depends on fix_tcc_pkg

module fix_tcc_path (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic                    clear_i,
  input  logic [7:0]              delim_i,
  input  logic [7:0]              byte_i,
  input  logic [7:0]              sum_next_i,
  output fix_tcc_pkg::path_view_t view_o
);
  import fix_tcc_pkg::*;

  path_view_t          view_q, view_d;
  logic [ProdW-1:0]    prod;
  logic [7:0]          digit;

  always_comb begin
    view_d = view_q;
    digit  = byte_i - CHAR_ZERO;
    prod   = {{(ProdW-ValueW){1'b0}}, view_q.value} * ProdW'(10)
             + {{(ProdW-8){1'b0}}, digit};
    case (view_q.stage)
      ST_SEARCH, ST_DELIM, ST_ONE, ST_ZERO: begin
        if (byte_i == delim_i) begin
          view_d.stage      = ST_DELIM;
          view_d.frozen_sum = sum_next_i;
        end else if (view_q.stage == ST_DELIM && byte_i == CHAR_ONE) begin
          view_d.stage = ST_ONE;
        end else if (view_q.stage == ST_ONE && byte_i == CHAR_ZERO) begin
          view_d.stage = ST_ZERO;
        end else if (view_q.stage == ST_ZERO && byte_i == CHAR_EQ) begin
          view_d.stage = ST_VALUE;
        end else begin
          view_d.stage = ST_SEARCH;
        end
      end
      ST_VALUE: begin
        if (byte_i == delim_i) begin
          view_d.stage = ST_ENDED;
        end else if (byte_i inside {[CHAR_ZERO:CHAR_NINE]}) begin
          // saturate so long values cannot wrap back into range
          view_d.value      = (prod > {{(ProdW-ValueW){1'b0}}, VALUE_SAT}) ?
                              VALUE_SAT : prod[ValueW-1:0];
          view_d.digit_seen = 1'b1;
        end else begin
          view_d.bad_digit = 1'b1;
        end
      end
      default: begin
        view_d = view_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q <= '0;
    end else if (step_i) begin
      if (clear_i) begin
        view_q <= '0;
      end else begin
        view_q <= view_d;
      end
    end
  end

  assign view_o = view_d;

endmodule
